/* rtl/lfua_pkg.sv */
// Shared types, widths and helpers for the lowest free unit allocator.
package lfua_pkg;

    localparam int NUM_UNITS_DEF = 64;
    localparam int TIME_BITS_DEF = 32;

    localparam int IN_TIME_W = 32;
    localparam int INDEX_W   = 6;
    localparam int USES_W    = 16;
    localparam int OPENED_W  = 7;

    localparam logic [USES_W-1:0] USES_MAX = '1;

    typedef struct packed {
        logic [IN_TIME_W-1:0] start_time;
        logic [IN_TIME_W-1:0] end_time;
        logic                 last_request;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  unit_index;
        logic [USES_W-1:0]   unit_uses;
        logic [OPENED_W-1:0] units_opened;
        logic                all_busy;
        logic                batch_done;
    } rsp_t;

    // Allocation decision carried down the pipe with each request
    typedef struct packed {
        logic found;
        logic all_busy;
        logic batch_done;
        logic fresh;
    } alloc_t;

    function automatic logic [USES_W-1:0] sat_inc(input logic [USES_W-1:0] v);
        return (v == USES_MAX) ? v : v + 1'b1;
    endfunction

endpackage

/* rtl/lfua_stream_if.sv */
// Valid/ready stream channel carrying one payload of type T.
interface lfua_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lowest_free_unit_allocator.sv */
// Top level: interval partitioning onto the lowest free unit.
//
// Channels: req (sink) takes booking requests (start_time, end_time,
// last_request); rsp (source) returns one result per request: unit_index,
// unit_uses, units_opened, all_busy and batch_done. A request moves on
// each rising edge where valid and ready are both high.
// Pipeline: input register, allocate stage (parallel end-time compare and
// priority encoder over all units, use-count RAM read), count stage (RAM
// data, saturating increment, write back) and the result register.
// A taken request passes the input register, the allocate-stage registers and the result register.
// Throughput: one request per cycle while rsp.ready is high; the free compare and
// the encoder sit in the allocate stage, and the use-count RAM is read once per
// request and written once per served request, with forwarding between neighbors.
// A request flagged last_request gets its result, then the batch state clears.
// Reset: all units close and use counts read as zero; no clearing pass.
// When the receiver holds rsp.ready low, the result waits in its register
// and the pipe fills; req.ready drops once all three stages hold requests.
module lowest_free_unit_allocator
    import lfua_pkg::*;
#(
    parameter int NUM_UNITS = NUM_UNITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lfua_stream_if.sink          req,
    lfua_stream_if.source        rsp
);

    localparam int IDX_W = $clog2(NUM_UNITS);
    localparam int CNT_W = $clog2(NUM_UNITS + 1);

    logic              v1_reg;
    req_t              req_reg;
    logic              v2_reg;
    logic [IDX_W-1:0]  pick2_reg;
    alloc_t            ctrl2_reg;
    logic [CNT_W-1:0]  opened2_reg;
    logic              v3_reg;
    rsp_t              rsp_reg;

    logic              ready1;
    logic              ready2;
    logic              ready3;
    logic              t12;
    logic              t23;

    logic [IDX_W-1:0]  pick;
    logic              found;
    logic              fresh;
    logic [CNT_W-1:0]  opened_after;
    logic [USES_W-1:0] uses;
    alloc_t            ctrl;

    assign ready3 = !v3_reg || rsp.ready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign t12    = v1_reg && ready2;
    assign t23    = v2_reg && ready3;

    assign req.ready = ready1;
    assign rsp.valid = v3_reg;
    assign rsp.data  = rsp_reg;

    lfua_cells #(
        .NUM_UNITS (NUM_UNITS),
        .TIME_BITS (TIME_BITS)
    ) u_cells (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_time   (req_reg.start_time),
        .end_time     (req_reg.end_time),
        .last_request (req_reg.last_request),
        .commit       (t12),
        .pick         (pick),
        .found        (found),
        .fresh        (fresh),
        .opened_after (opened_after)
    );

    assign ctrl.found      = found;
    assign ctrl.all_busy   = !found;
    assign ctrl.batch_done = req_reg.last_request;
    assign ctrl.fresh      = fresh;

    lfua_count #(
        .NUM_UNITS (NUM_UNITS)
    ) u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (t12),
        .rd_addr (pick),
        .retire  (t23),
        .b_pick  (pick2_reg),
        .b_ctrl  (ctrl2_reg),
        .uses    (uses)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= req.valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && ready1)
        begin
            req_reg <= req.data;
        end
        if (t12)
        begin
            pick2_reg   <= pick;
            ctrl2_reg   <= ctrl;
            opened2_reg <= opened_after;
        end
        if (t23)
        begin
            rsp_reg.unit_index   <= ctrl2_reg.found ? INDEX_W'(pick2_reg) : '0;
            rsp_reg.unit_uses    <= uses;
            rsp_reg.units_opened <= OPENED_W'(opened2_reg);
            rsp_reg.all_busy     <= ctrl2_reg.all_busy;
            rsp_reg.batch_done   <= ctrl2_reg.batch_done;
        end
    end

`ifndef SYNTH
    a_pick_opened: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && ctrl2_reg.found |-> CNT_W'(pick2_reg) < opened2_reg)
        else $error("assigned unit is not among the opened units");

    a_served_uses: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.all_busy |-> rsp.data.unit_uses != '0)
        else $error("served request reports a zero use count");

    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && ctrl2_reg.all_busy |-> opened2_reg == CNT_W'(NUM_UNITS))
        else $error("request dropped while a unit could still open");
`endif

endmodule

/* rtl/lfua_ram.sv */
// Generic simple dual-port RAM with registered read.
module lfua_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lfua_cells.sv */
// Per-unit end-time cells, free compare and lowest-index priority encoder.
module lfua_cells
    import lfua_pkg::*;
#(
    parameter int NUM_UNITS = NUM_UNITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int IDX_W    = $clog2(NUM_UNITS),
    localparam int CNT_W    = $clog2(NUM_UNITS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IN_TIME_W-1:0] start_time,
    input  logic [IN_TIME_W-1:0] end_time,
    input  logic                 last_request,
    input  logic                 commit,
    output logic [IDX_W-1:0]     pick,
    output logic                 found,
    output logic                 fresh,
    output logic [CNT_W-1:0]     opened_after
);

    logic [TIME_BITS-1:0] busy_until_reg [NUM_UNITS];
    logic [CNT_W-1:0]     opened_reg;
    logic [CNT_W-1:0]     opened_next;
    logic [TIME_BITS-1:0] start_t;
    logic [TIME_BITS-1:0] end_t;
    logic [NUM_UNITS-1:0] free;
    logic [NUM_UNITS-1:0] lowest;
    logic [IDX_W-1:0]     pick_enc;
    logic                 any_free;
    logic                 can_open;

    assign start_t = TIME_BITS'(start_time);
    assign end_t   = TIME_BITS'(end_time);

    always_comb
    begin
        for (int i = 0; i < NUM_UNITS; i++)
        begin
            free[i] = (CNT_W'(i) < opened_reg) && (busy_until_reg[i] <= start_t);
        end
    end

    // isolate the lowest set bit, then encode it
    assign lowest = free & (~free + 1'b1);

    always_comb
    begin
        pick_enc = '0;
        for (int i = 0; i < NUM_UNITS; i++)
        begin
            pick_enc = pick_enc | (lowest[i] ? IDX_W'(i) : '0);
        end
    end

    assign any_free = |free;
    assign can_open = (opened_reg != CNT_W'(NUM_UNITS));
    assign found    = any_free || can_open;
    assign pick     = any_free ? pick_enc : IDX_W'(opened_reg);

    // a newly opened unit has not been used yet in this batch
    assign fresh = !any_free && can_open;

    assign opened_after = fresh ? opened_reg + 1'b1 : opened_reg;

    always_comb
    begin
        opened_next = opened_reg;
        if (commit)
        begin
            opened_next = last_request ? '0 : opened_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opened_reg <= '0;
        end
        else
        begin
            opened_reg <= opened_next;
        end
    end

    // only opened units are compared, so the end times need no reset
    always_ff @(posedge clk)
    begin
        if (commit && found)
        begin
            busy_until_reg[pick] <= end_t;
        end
    end

endmodule

/* rtl/lfua_count.sv */
// Use counters: RAM with write forwarding; a newly opened unit counts from zero.
module lfua_count
    import lfua_pkg::*;
#(
    parameter int NUM_UNITS = NUM_UNITS_DEF,
    localparam int IDX_W    = $clog2(NUM_UNITS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic              retire,
    input  logic [IDX_W-1:0]  b_pick,
    input  alloc_t            b_ctrl,
    output logic [USES_W-1:0] uses
);

    logic [USES_W-1:0]    rdata;
    logic                 fwd_valid_reg;
    logic [IDX_W-1:0]     fwd_addr_reg;
    logic [USES_W-1:0]    fwd_data_reg;
    logic [USES_W-1:0]    cur;
    logic                 we;

    lfua_ram #(
        .WIDTH (USES_W),
        .DEPTH (NUM_UNITS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (b_pick),
        .wdata (uses),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign we = retire && b_ctrl.found;

    // RAM read misses a write landing on the same edge; take it from fwd
    always_comb
    begin
        if (b_ctrl.fresh)
        begin
            cur = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == b_pick))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = rdata;
        end
    end

    assign uses = b_ctrl.found ? sat_inc(cur) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                fwd_valid_reg <= we;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_addr_reg <= b_pick;
            fwd_data_reg <= uses;
        end
    end

endmodule

/* verif/lowest_free_unit_allocator_test.sv */
// Self-checking testbench for the lowest free unit allocator: directed table, then random batches.
module lowest_free_unit_allocator_test;
    import lfua_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS        = NUM_UNITS_DEF;
    localparam int RANDOM_ITEMS = 1470;
    localparam int CALM_TAIL    = 200;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int MAX_PRINTED  = 40;

    // One row of the directed table; the typed result applies to the final repeat only
    typedef struct packed {
        logic [IN_TIME_W-1:0] start_time;
        logic [IN_TIME_W-1:0] end_time;
        logic                 last_request;
        int                   repeats;
        logic                 typed;
        logic [INDEX_W-1:0]   unit_index;
        logic [USES_W-1:0]    unit_uses;
        logic [OPENED_W-1:0]  units_opened;
        logic                 all_busy;
        logic                 batch_done;
    } booking_row_t;

    localparam booking_row_t BOOKING_PLAN [15] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1,     1'b1, 6'd0, 16'd1,      7'd1,  1'b0, 1'b0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1,     1'b1, 6'd0, 16'd2,      7'd1,  1'b0, 1'b0},
        '{32'h0000_0001, 32'h0000_0005, 1'b0, 1,     1'b0, 6'd0, 16'd0,      7'd0,  1'b0, 1'b0},
        '{32'h0000_0005, 32'h0000_0007, 1'b0, 1,     1'b0, 6'd0, 16'd0,      7'd0,  1'b0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1,     1'b1, 6'd0, 16'd3,      7'd2,  1'b0, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1,     1'b1, 6'd0, 16'd1,      7'd1,  1'b0, 1'b0},
        '{32'h0000_0000, 32'h0000_000A, 1'b0, 1,     1'b0, 6'd0, 16'd0,      7'd0,  1'b0, 1'b0},
        '{32'h0000_0064, 32'h0000_00C8, 1'b0, 1,     1'b0, 6'd0, 16'd0,      7'd0,  1'b0, 1'b0},
        // start goes backward: judged only against stored end times
        '{32'h0000_0032, 32'h0000_003C, 1'b0, 1,     1'b0, 6'd0, 16'd0,      7'd0,  1'b0, 1'b0},
        // reuse units 0 and 1, then open the rest until every unit is held forever
        '{32'h0000_012C, 32'hFFFF_FFFF, 1'b0, 64,    1'b0, 6'd0, 16'd0,      7'd0,  1'b0, 1'b0},
        '{32'h0000_0190, 32'h0000_01F4, 1'b0, 1,     1'b1, 6'd0, 16'd0,      7'd64, 1'b1, 1'b0},
        '{32'hFFFF_FFFE, 32'h0000_0000, 1'b1, 1,     1'b1, 6'd0, 16'd0,      7'd64, 1'b1, 1'b1},
        // same unit over and over
        '{32'h0000_0007, 32'h0000_0007, 1'b0, 3,     1'b1, 6'd0, 16'd3,      7'd1,  1'b0, 1'b0},
        '{32'h0000_0008, 32'h0000_0008, 1'b1, 1,     1'b1, 6'd0, 16'd4,      7'd1,  1'b0, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1,     1'b1, 6'd0, 16'd1,      7'd1,  1'b0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    lfua_stream_if #(.T(req_t)) req_if ();
    lfua_stream_if #(.T(rsp_t)) rsp_if ();

    lowest_free_unit_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #2 clk = ~clk;

    // Predictor state: per-unit end time and use count, units opened in this batch
    logic [IN_TIME_W-1:0] unit_free_at [UNITS];
    logic [USES_W-1:0]    unit_use_count [UNITS];
    int                   units_open;

    rsp_t expected_allocs [$];
    int   error_count;
    int   requests_taken;
    int   allocs_checked;
    int   drops_seen;
    int   batches_closed;
    int   cycle_count;
    bit   idle_on;
    int   ready_hold;

    function automatic void clear_batch();
        for (int i = 0; i < UNITS; i++)
        begin
            unit_free_at[i]   = '0;
            unit_use_count[i] = '0;
        end
        units_open = 0;
    endfunction

    function automatic rsp_t allocate_unit(input req_t r);
        rsp_t res;
        int   pick;
        bit   found;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        for (int i = 0; i < units_open; i++)
        begin
            if (!found && unit_free_at[i] <= r.start_time)
            begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (!found && units_open < UNITS)
        begin
            pick  = units_open;
            units_open++;
            found = 1'b1;
        end
        if (found)
        begin
            unit_free_at[pick] = r.end_time;
            if (unit_use_count[pick] != USES_MAX)
                unit_use_count[pick] = unit_use_count[pick] + 1'b1;
            res.unit_index = INDEX_W'(pick);
            res.unit_uses  = unit_use_count[pick];
        end
        else
            res.all_busy = 1'b1;
        res.units_opened = OPENED_W'(units_open);
        res.batch_done   = r.last_request;
        if (r.last_request)
            clear_batch();
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_alloc(input rsp_t got);
        rsp_t want;
        if (expected_allocs.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: %p", got));
            return;
        end
        want = expected_allocs.pop_front();
        if (got.unit_index !== want.unit_index)
            report_mismatch($sformatf("result %0d unit_index %0d, want %0d",
                allocs_checked, got.unit_index, want.unit_index));
        if (got.unit_uses !== want.unit_uses)
            report_mismatch($sformatf("result %0d unit_uses %0d, want %0d",
                allocs_checked, got.unit_uses, want.unit_uses));
        if (got.units_opened !== want.units_opened)
            report_mismatch($sformatf("result %0d units_opened %0d, want %0d",
                allocs_checked, got.units_opened, want.units_opened));
        if (got.all_busy !== want.all_busy)
            report_mismatch($sformatf("result %0d all_busy %0b, want %0b",
                allocs_checked, got.all_busy, want.all_busy));
        if (got.batch_done !== want.batch_done)
            report_mismatch($sformatf("result %0d batch_done %0b, want %0b",
                allocs_checked, got.batch_done, want.batch_done));
        if (got.all_busy === 1'b1)
            drops_seen++;
        if (got.batch_done === 1'b1)
            batches_closed++;
        allocs_checked++;
    endtask

    // Offer one request; the prediction is made when it is taken
    task automatic send_request(input req_t r, input bit typed, input rsp_t given);
        rsp_t predicted;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predicted = allocate_unit(r);
        expected_allocs.push_back(typed ? given : predicted);
        requests_taken++;
    endtask

    // Receiver: random stall bursts, checks every taken result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_alloc(rsp_if.data);
        if (rst_n !== 1'b1)
            rsp_if.ready <= 1'b0;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            rsp_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            ready_hold = $urandom_range(1, 8) - 1;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                cycle_count, expected_allocs.size());
            $display("lowest_free_unit_allocator_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        req_t                 r;
        rsp_t                 given;
        booking_row_t         row;
        int                   random_sent;
        int                   kind;
        int                   batch_len;
        logic [IN_TIME_W-1:0] t_start;
        logic [IN_TIME_W-1:0] t_end;
        logic [IN_TIME_W-1:0] prev_end;
        int                   step;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        error_count    = 0;
        requests_taken = 0;
        allocs_checked = 0;
        drops_seen     = 0;
        batches_closed = 0;
        cycle_count    = 0;
        ready_hold     = 0;
        idle_on        = 1'b1;
        clear_batch();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (BOOKING_PLAN[k])
        begin
            row = BOOKING_PLAN[k];
            r.start_time   = row.start_time;
            r.end_time     = row.end_time;
            r.last_request = row.last_request;
            given = '{row.unit_index, row.unit_uses, row.units_opened,
                      row.all_busy, row.batch_done};
            for (int n = 0; n < row.repeats; n++)
                send_request(r, row.typed && n == row.repeats - 1, given);
        end

        random_sent = 0;
        given = '0;
        while (random_sent < RANDOM_ITEMS)
        begin
            idle_on = (random_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise: any values, backward starts, stray batch ends
                batch_len = $urandom_range(1, 6);
                for (int n = 0; n < batch_len; n++)
                begin
                    r.start_time   = $urandom;
                    r.end_time     = $urandom;
                    r.last_request = ($urandom_range(0, 7) == 0);
                    send_request(r, 1'b0, given);
                    random_sent++;
                end
            end
            else
            begin
                // well-formed batch; a crowded one can overrun every unit
                batch_len = (kind == 1) ? $urandom_range(60, 75) : $urandom_range(1, 40);
                t_start   = $urandom_range(0, 32'hFFF0_0000);
                prev_end  = '0;
                for (int n = 0; n < batch_len; n++)
                begin
                    step = (kind == 1) ? $urandom_range(0, 2) :
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000) :
                                                         $urandom_range(0, 4);
                    if (n > 0)
                        t_start = t_start + step;
                    if (kind == 1)
                        t_end = t_start + $urandom_range(1000, 100000);
                    else if ($urandom_range(0, 15) == 0)
                        t_end = $urandom;
                    else
                        t_end = t_start + $urandom_range(0, 12);
                    // equal starts come in end order
                    if (n > 0 && step == 0 && t_end < prev_end)
                        t_end = prev_end;
                    prev_end       = t_end;
                    r.start_time   = t_start;
                    r.end_time     = t_end;
                    r.last_request = (n == batch_len - 1);
                    send_request(r, 1'b0, given);
                    random_sent++;
                end
            end
        end
        req_if.valid <= 1'b0;
        idle_on = 1'b0;

        while (expected_allocs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d dropped on full, %0d batches",
            requests_taken, allocs_checked, drops_seen, batches_closed);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("lowest_free_unit_allocator_test: done, clean");
        else
            $display("lowest_free_unit_allocator_test: done, errors");
        $finish;
    end

endmodule
